[hdl/stl_pkg.sv]
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types, character codes and classification helpers for the lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

  // lexer mode, one-hot
  typedef enum logic [6:0] {
    M_IDLE    = 7'b0000001,
    M_WORD    = 7'b0000010,
    M_NUM     = 7'b0000100,
    M_COLON   = 7'b0001000,
    M_COMMENT = 7'b0010000,
    M_ERROR   = 7'b0100000,
    M_DONE    = 7'b1000000
  } mode_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // results one input word can produce
  localparam int          MAX_RES = 4;
  localparam logic [2:0]  RES_MAX = 3'(MAX_RES);

  // packet queue between front and back
  localparam int          QDEPTH  = 4;
  localparam int          QPTR_W  = $clog2(QDEPTH);
  localparam int          QLVL_W  = $clog2(QDEPTH + 1);

  // burst of result words caused by one input word
  typedef struct packed {
    logic [2:0]         count;
    logic [3:0][7:0]    bytes;
    logic [3:0]         errs;
  } pkt_t;

  typedef struct packed {
    pkt_t  pkt;
    mode_t mode;
  } step_t;

  typedef struct packed {
    logic              full;
    logic              avail;
    logic [QLVL_W-1:0] level;
  } q_stat_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_word_start(logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
           (b == CH_DASH) || (b == CH_UNDER);
  endfunction

  function automatic logic is_symbol(logic [7:0] b);
    return (b == CH_LPAR) || (b == CH_RPAR) || (b == CH_EQ) || (b == CH_DOT) ||
           (b == CH_QUOTE);
  endfunction

  // append one result to a packet; extra results beyond the limit are dropped
  function automatic pkt_t push(pkt_t p, logic [7:0] b, logic e);
    pkt_t r;
    r = p;
    if (p.count < RES_MAX) begin
      r.bytes[p.count[1:0]] = b;
      r.errs[p.count[1:0]]  = e;
      r.count               = p.count + 3'd1;
    end
    return r;
  endfunction

  // classify a byte seen between tokens
  function automatic step_t dispatch(pkt_t p, logic [7:0] b);
    step_t r;
    r.pkt  = p;
    r.mode = M_IDLE;
    if (b == CH_NUL) begin
      r.pkt  = push(p, CH_NUL, 1'b0);
      r.mode = M_DONE;
    end else if ((b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL)) begin
      r.mode = M_IDLE;
    end else if (is_symbol(b)) begin
      r.pkt  = push(push(p, b, 1'b0), CH_SPACE, 1'b0);
      r.mode = M_IDLE;
    end else if (b == CH_HASH) begin
      r.mode = M_COMMENT;
    end else if (b == CH_COLON) begin
      r.pkt  = push(p, b, 1'b0);
      r.mode = M_COLON;
    end else if (is_digit(b)) begin
      r.pkt  = push(p, b, 1'b0);
      r.mode = M_NUM;
    end else if (is_word_start(b)) begin
      r.pkt  = push(p, b, 1'b0);
      r.mode = M_WORD;
    end else begin
      r.pkt  = push(p, CH_NUL, 1'b1);
      r.mode = M_ERROR;
    end
    return r;
  endfunction

endpackage

[hdl/stl_front.sv]
// ----------------------------------------------------------------------------
// stl_front
// Accepts source bytes, tracks the lexer mode and builds one result packet
// per byte.
// ----------------------------------------------------------------------------
module stl_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              text_end,
  input  stl_pkg::q_stat_t  q_stat,
  output logic              q_push,
  output stl_pkg::pkt_t     q_pkt
);

  stl_pkg::mode_t lex_mode;
  stl_pkg::step_t s;
  logic           was_error;
  logic           accept;

  always_comb begin
    s.pkt     = '0;
    s.mode    = lex_mode;
    was_error = (lex_mode == stl_pkg::M_ERROR);
    case (lex_mode)
      stl_pkg::M_WORD: begin
        if (stl_pkg::is_word_start(in_byte) || stl_pkg::is_digit(in_byte)) begin
          s.pkt = stl_pkg::push(s.pkt, in_byte, 1'b0);
        end else begin
          s = stl_pkg::dispatch(stl_pkg::push(s.pkt, stl_pkg::CH_SPACE, 1'b0), in_byte);
        end
      end
      stl_pkg::M_NUM: begin
        if (stl_pkg::is_digit(in_byte)) begin
          s.pkt = stl_pkg::push(s.pkt, in_byte, 1'b0);
        end else begin
          s = stl_pkg::dispatch(stl_pkg::push(s.pkt, stl_pkg::CH_SPACE, 1'b0), in_byte);
        end
      end
      stl_pkg::M_COLON: begin
        if (in_byte == stl_pkg::CH_COLON) begin
          s.pkt = stl_pkg::push(s.pkt, in_byte, 1'b0);
        end else begin
          s = stl_pkg::dispatch(stl_pkg::push(s.pkt, stl_pkg::CH_SPACE, 1'b0), in_byte);
        end
      end
      stl_pkg::M_COMMENT: begin
        if (in_byte == stl_pkg::CH_NL) begin
          s.mode = stl_pkg::M_IDLE;
        end else if (in_byte == stl_pkg::CH_NUL) begin
          s.pkt  = stl_pkg::push(s.pkt, stl_pkg::CH_NUL, 1'b0);
          s.mode = stl_pkg::M_DONE;
        end
      end
      stl_pkg::M_ERROR, stl_pkg::M_DONE: begin
        s.mode = lex_mode;
      end
      default: begin
        s = stl_pkg::dispatch(s.pkt, in_byte);
      end
    endcase

    // end of text: close an open token and terminate, unless done or newly in error
    if (text_end) begin
      if (s.mode == stl_pkg::M_ERROR) begin
        if (was_error) begin
          s.pkt = stl_pkg::push(s.pkt, stl_pkg::CH_NUL, 1'b1);
        end
      end else if (s.mode != stl_pkg::M_DONE) begin
        if ((s.mode == stl_pkg::M_WORD) || (s.mode == stl_pkg::M_NUM) ||
            (s.mode == stl_pkg::M_COLON)) begin
          s.pkt = stl_pkg::push(s.pkt, stl_pkg::CH_SPACE, 1'b0);
        end
        s.pkt = stl_pkg::push(s.pkt, stl_pkg::CH_NUL, 1'b0);
      end
      s.mode = stl_pkg::M_IDLE;
    end
  end

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (s.pkt.count != 3'd0);
  assign q_pkt    = s.pkt;

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode <= stl_pkg::M_IDLE;
    end else if (accept) begin
      lex_mode <= s.mode;
    end
  end

endmodule

[hdl/stl_queue.sv]
// ----------------------------------------------------------------------------
// stl_queue
// Short packet queue between front and back.
// ----------------------------------------------------------------------------
module stl_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  stl_pkg::pkt_t     wr_pkt,
  input  logic              pop,
  output stl_pkg::pkt_t     head,
  output stl_pkg::q_stat_t  q_stat
);

  stl_pkg::pkt_t                  mem [stl_pkg::QDEPTH];
  logic [stl_pkg::QPTR_W-1:0]     wr_ptr;
  logic [stl_pkg::QPTR_W-1:0]     rd_ptr;
  logic [stl_pkg::QLVL_W-1:0]     level;
  logic [stl_pkg::QLVL_W-1:0]     level_next;

  assign head          = mem[rd_ptr];
  assign q_stat.full   = (level == stl_pkg::QLVL_W'(stl_pkg::QDEPTH));
  assign q_stat.avail  = (level != '0);
  assign q_stat.level  = level;

  always_comb begin
    case ({push, pop})
      2'b10:   level_next = level + stl_pkg::QLVL_W'(1);
      2'b01:   level_next = level - stl_pkg::QLVL_W'(1);
      default: level_next = level;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + stl_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + stl_pkg::QPTR_W'(1);
      end
      level <= level_next;
    end
  end

endmodule

[hdl/stl_back.sv]
// ----------------------------------------------------------------------------
// stl_back
// Unpacks the head packet into single result words through an output register.
// ----------------------------------------------------------------------------
module stl_back (
  input  logic              clk,
  input  logic              rst,
  input  stl_pkg::pkt_t     head,
  input  stl_pkg::q_stat_t  q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              lex_error,
  output logic              run_last
);

  logic [1:0] idx;
  logic       load;
  logic       last_here;

  assign load      = q_stat.avail && (!out_valid || out_ready);
  assign last_here = (({1'b0, idx} + 3'd1) == head.count);
  assign pop       = load && last_here;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= last_here ? 2'd0 : idx + 2'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= head.bytes[idx];
      lex_error <= head.errs[idx];
      run_last  <= last_here;
    end
  end

endmodule

[hdl/source_token_lexer.sv]
// ----------------------------------------------------------------------------
// source_token_lexer: source bytes in, token stream out (rates below).
// Path: each result word passes through the packet queue, then the output register.
// Throughput: 1 input word per cycle while the packet queue has room; results leave
// at 1 word per cycle while out_ready is high; the output port sets the sustained rate.
// Reset (rst, synchronous): lexer idle between tokens, queue and output empty.
// ----------------------------------------------------------------------------
module source_token_lexer (
  input  logic       clk,
  input  logic       rst,
  // source text
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       text_end,
  // token stream
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       lex_error,
  output logic       run_last
);

  // The front classifies each byte against the current mode and writes
  // the 1..4 result words it causes as one packet into a short queue.
  // Bytes that cause nothing (separators, comment text, dropped text)
  // never enter the queue. The back drains the head packet one word per cycle
  // while out_ready allows, into the output register; both sides stall independently.

  stl_pkg::pkt_t     q_wr_pkt;
  stl_pkg::pkt_t     q_head;
  stl_pkg::q_stat_t  q_stat;
  logic              q_push;
  logic              q_pop;

  stl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .text_end (text_end),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_pkt    (q_wr_pkt)
  );

  stl_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_pkt (q_wr_pkt),
    .pop    (q_pop),
    .head   (q_head),
    .q_stat (q_stat)
  );

  stl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .lex_error (lex_error),
    .run_last  (run_last)
  );

`ifndef NO_ASSERTIONS
  // error results always carry a zero byte
  a_err_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && lex_error |-> out_byte == stl_pkg::CH_NUL)
    else $error("error result with nonzero byte");

  // rest of a burst is already queued, so the output refills at once
  a_burst_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !run_last |=> out_valid)
    else $error("gap inside a result burst");

  // queue occupancy stays within its depth
  a_q_level: assert property (@(posedge clk) disable iff (rst)
    q_stat.level <= stl_pkg::QLVL_W'(stl_pkg::QDEPTH))
    else $error("packet queue overflow");

  // a full queue holds off the source
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !in_ready && !q_push)
    else $error("write into full packet queue");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: source_token_lexer
// Feeds source text one byte per handshake and checks the token stream word
// by word against an in-bench model of the lexer. A short table of directed
// words comes first, then random texts built mostly from legal tokens, with
// random gaps on the source side and random stalls on the token side.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LIMIT     = 400000;  // cycles before the run is called hung
  localparam int N_RANDOM  = 300;     // random source words, roughly
  localparam int DRAIN_CYC = 12;      // padding after the last owed word is taken

  // one word of the token stream
  typedef struct packed {
    logic [7:0] ch;
    logic       err;
    logic       last;
  } tok_word_t;

  // one directed row; typed rows carry their results inline (all zero bytes)
  typedef struct {
    logic [7:0] ch;
    logic       fin;
    bit         typed;
    int         n;
    logic       terr;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       text_end;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       lex_error;
  logic       run_last;

  source_token_lexer u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .text_end (text_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .lex_error(lex_error),
    .run_last (run_last)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Lexer model: its own mode register plus a burst buffer for the words that
  // one source word produces (never more than MAX_RES).
  // --------------------------------------------------------------------------
  stl_pkg::mode_t lex_state;
  logic [7:0]     burst_ch  [stl_pkg::MAX_RES];
  logic           burst_err [stl_pkg::MAX_RES];
  int             burst_n;

  tok_word_t  pending_words[$];   // token words still owed by the DUT
  stim_row_t  directed_rows[$];

  int fail_count    = 0;
  int words_sent    = 0;
  int texts_sent    = 0;
  int words_checked = 0;
  int bad_bytes     = 0;
  int cycle_count   = 0;

  function automatic bit num_char(logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  // letters, '-' and '_' may open a word; digits may only continue one
  function automatic bit word_char(logic [7:0] b);
    return b inside {[8'h41:8'h5A], [8'h61:8'h7A], stl_pkg::CH_DASH, stl_pkg::CH_UNDER};
  endfunction

  function automatic void add_word(logic [7:0] c, logic e);
    if (burst_n < stl_pkg::MAX_RES) begin
      burst_ch[burst_n]  = c;
      burst_err[burst_n] = e;
      burst_n++;
    end
  endfunction

  // classify a byte with no token open
  function automatic void start_token(logic [7:0] b);
    if (b == stl_pkg::CH_NUL) begin
      add_word(stl_pkg::CH_NUL, 1'b0);
      lex_state = stl_pkg::M_DONE;
    end else if (b inside {stl_pkg::CH_SPACE, stl_pkg::CH_TAB, stl_pkg::CH_NL}) begin
      lex_state = stl_pkg::M_IDLE;
    end else if (b inside {stl_pkg::CH_LPAR, stl_pkg::CH_RPAR, stl_pkg::CH_EQ,
                           stl_pkg::CH_DOT, stl_pkg::CH_QUOTE}) begin
      add_word(b, 1'b0);
      add_word(stl_pkg::CH_SPACE, 1'b0);
      lex_state = stl_pkg::M_IDLE;
    end else if (b == stl_pkg::CH_HASH) begin
      lex_state = stl_pkg::M_COMMENT;
    end else if (b == stl_pkg::CH_COLON) begin
      add_word(b, 1'b0);
      lex_state = stl_pkg::M_COLON;
    end else if (num_char(b)) begin
      add_word(b, 1'b0);
      lex_state = stl_pkg::M_NUM;
    end else if (word_char(b)) begin
      add_word(b, 1'b0);
      lex_state = stl_pkg::M_WORD;
    end else begin
      // fits no class: a single error word, then drop to the end of the text
      add_word(stl_pkg::CH_NUL, 1'b1);
      lex_state = stl_pkg::M_ERROR;
    end
  endfunction

  // advance the model by one accepted source word; queue its results if keep
  function automatic void predict_tokens(logic [7:0] b, logic fin, bit keep);
    stl_pkg::mode_t prior;
    prior   = lex_state;
    burst_n = 0;
    case (lex_state)
      stl_pkg::M_WORD: begin
        if (word_char(b) || num_char(b)) add_word(b, 1'b0);
        else begin
          add_word(stl_pkg::CH_SPACE, 1'b0);
          start_token(b);
        end
      end
      stl_pkg::M_NUM: begin
        if (num_char(b)) add_word(b, 1'b0);
        else begin
          add_word(stl_pkg::CH_SPACE, 1'b0);
          start_token(b);
        end
      end
      stl_pkg::M_COLON: begin
        if (b == stl_pkg::CH_COLON) add_word(b, 1'b0);
        else begin
          add_word(stl_pkg::CH_SPACE, 1'b0);
          start_token(b);
        end
      end
      stl_pkg::M_COMMENT: begin
        // everything but newline and zero vanishes, bad bytes included
        if (b == stl_pkg::CH_NL) lex_state = stl_pkg::M_IDLE;
        else if (b == stl_pkg::CH_NUL) begin
          add_word(stl_pkg::CH_NUL, 1'b0);
          lex_state = stl_pkg::M_DONE;
        end
      end
      stl_pkg::M_ERROR, stl_pkg::M_DONE: ;
      default: start_token(b);
    endcase
    if (fin) begin
      // end of text: close an open token and terminate, unless already done.
      // In error mode a terminator comes only if the bad byte was earlier.
      if (lex_state == stl_pkg::M_ERROR) begin
        if (prior == stl_pkg::M_ERROR) add_word(stl_pkg::CH_NUL, 1'b1);
      end else if (lex_state != stl_pkg::M_DONE) begin
        if (lex_state inside {stl_pkg::M_WORD, stl_pkg::M_NUM, stl_pkg::M_COLON})
          add_word(stl_pkg::CH_SPACE, 1'b0);
        add_word(stl_pkg::CH_NUL, 1'b0);
      end
      lex_state = stl_pkg::M_IDLE;
    end
    if (keep) begin
      for (int i = 0; i < burst_n; i++)
        pending_words.push_back('{ch: burst_ch[i], err: burst_err[i],
                                   last: (i == burst_n - 1)});
    end
  endfunction

  // --------------------------------------------------------------------------
  // Source side
  // --------------------------------------------------------------------------
  task automatic add_row(logic [7:0] c, logic f, bit typed, int n, logic e);
    directed_rows.push_back('{ch: c, fin: f, typed: typed, n: n, terr: e});
  endtask

  // present one word at the falling edge and hold it until taken
  task automatic send_word(logic [7:0] c, logic f);
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte  <= c;
    text_end <= f;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (!num_char(c) && !word_char(c) && c >= 8'h80) bad_bytes++;
  endtask

  // random hold-off between words: mostly none, some short, a few long
  task automatic idle_gap(bit steady);
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = 0;
    if (!steady) begin
      if (r >= 90) n = $urandom_range(8, 30);
      else if (r >= 60) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_byte  <= 8'($urandom);
      text_end <= 1'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // byte picker for random texts: mostly token material, some noise
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 26) begin
      case ($urandom_range(0, 5))
        0:       return stl_pkg::CH_DASH;
        1:       return stl_pkg::CH_UNDER;
        2, 3:    return 8'($urandom_range(8'h61, 8'h7A));
        default: return 8'($urandom_range(8'h41, 8'h5A));
      endcase
    end
    if (r < 42) return 8'($urandom_range(8'h30, 8'h39));
    if (r < 52) begin
      case ($urandom_range(0, 4))
        0:       return stl_pkg::CH_LPAR;
        1:       return stl_pkg::CH_RPAR;
        2:       return stl_pkg::CH_EQ;
        3:       return stl_pkg::CH_DOT;
        default: return stl_pkg::CH_QUOTE;
      endcase
    end
    if (r < 60) return stl_pkg::CH_COLON;
    if (r < 73) begin
      case ($urandom_range(0, 2))
        0:       return stl_pkg::CH_SPACE;
        1:       return stl_pkg::CH_TAB;
        default: return stl_pkg::CH_NL;
      endcase
    end
    if (r < 78) return stl_pkg::CH_HASH;
    if (r < 81) return stl_pkg::CH_NUL;
    if (r < 90) return 8'($urandom_range(0, 255));   // anything at all
    return 8'($urandom_range(8'h80, 8'hFF));          // high half: always bad
  endfunction

  initial begin
    stim_row_t row;
    int        len;
    bit        steady;
    logic [7:0] c;

    rst       = 1'b1;
    in_valid  = 1'b0;
    in_byte   = 8'h00;
    text_end  = 1'b0;
    lex_state = stl_pkg::M_IDLE;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table. Typed rows: bad byte, error then end of text, bad byte
    // carrying end of text, zero byte, word after the zero. The rest go
    // through the model: word chars, colon run, every symbol, separators,
    // a comment swallowing a bad byte, number closed by a word, and a symbol
    // with end of text right after a word (four results from one word).
    add_row(8'hFF,             1'b0, 1, 1, 1'b1);
    add_row("a",               1'b1, 1, 1, 1'b1);
    add_row(8'h80,             1'b1, 1, 1, 1'b1);
    add_row(stl_pkg::CH_NUL,   1'b0, 1, 1, 1'b0);
    add_row("x",               1'b1, 1, 0, 1'b0);
    add_row("A",               1'b0, 0, 0, 1'b0);
    add_row(stl_pkg::CH_UNDER, 1'b0, 0, 0, 1'b0);
    add_row("z",               1'b0, 0, 0, 1'b0);
    add_row(stl_pkg::CH_DASH,  1'b0, 0, 0, 1'b0);
    add_row("9",               1'b0, 0, 0, 1'b0);
    add_row(stl_pkg::CH_COLON, 1'b0, 0, 0, 1'b0);
    add_row(stl_pkg::CH_COLON, 1'b0, 0, 0, 1'b0);
    add_row(stl_pkg::CH_LPAR,  1'b0, 0, 0, 1'b0);
    add_row(stl_pkg::CH_RPAR,  1'b0, 0, 0, 1'b0);
    add_row(stl_pkg::CH_EQ,    1'b0, 0, 0, 1'b0);
    add_row(stl_pkg::CH_DOT,   1'b0, 0, 0, 1'b0);
    add_row(stl_pkg::CH_QUOTE, 1'b0, 0, 0, 1'b0);
    add_row(stl_pkg::CH_TAB,   1'b0, 0, 0, 1'b0);
    add_row(stl_pkg::CH_HASH,  1'b0, 0, 0, 1'b0);
    add_row(8'hFF,             1'b0, 0, 0, 1'b0);
    add_row(stl_pkg::CH_NL,    1'b0, 0, 0, 1'b0);
    add_row("1",               1'b0, 0, 0, 1'b0);
    add_row("2",               1'b0, 0, 0, 1'b0);
    add_row("b",               1'b0, 0, 0, 1'b0);
    add_row(stl_pkg::CH_EQ,    1'b1, 0, 0, 1'b0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_word(row.ch, row.fin);
      if (row.typed) begin
        predict_tokens(row.ch, row.fin, 1'b0);   // keep the model in step
        for (int k = 0; k < row.n; k++)
          pending_words.push_back('{ch: stl_pkg::CH_NUL, err: row.terr,
                                    last: (k == row.n - 1)});
      end else begin
        predict_tokens(row.ch, row.fin, 1'b1);
      end
      if (row.fin) texts_sent++;
      idle_gap(1'b0);
    end

    // Random texts: mostly short, the odd long one; some sent back to back
    while (words_sent < directed_rows.size() + N_RANDOM) begin
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      steady = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
        c = pick_byte();
        send_word(c, k == len - 1);
        predict_tokens(c, k == len - 1, 1'b1);
        idle_gap(steady);
      end
      texts_sent++;
    end

    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Sent %0d source words in %0d texts (%0d high-half bytes);",
             words_sent, texts_sent, bad_bytes);
    $display("checked %0d token words under random stalls.", words_checked);
    if (fail_count == 0 && pending_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Token side: random back-pressure with calm stretches
  // --------------------------------------------------------------------------
  initial begin
    int r;
    int n;
    out_ready = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      @(negedge clk);
      if (r < 50) begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 20);
      end else if (r < 90) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 3);
      end else begin
        out_ready <= 1'b0;
        n = $urandom_range(10, 40);
      end
      repeat (n - 1) @(negedge clk);
    end
  end

  // compare each taken token word with the oldest one owed
  always @(posedge clk) begin
    tok_word_t head;
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: out_byte %h lex_error %b run_last %b",
               out_byte, lex_error, run_last);
        fail_count++;
      end else begin
        head = pending_words.pop_front();
        words_checked++;
        if (out_byte !== head.ch) begin
          $error("out_byte: expected %h, got %h", head.ch, out_byte);
          fail_count++;
        end
        if (lex_error !== head.err) begin
          $error("lex_error: expected %b, got %b", head.err, lex_error);
          fail_count++;
        end
        if (run_last !== head.last) begin
          $error("run_last: expected %b, got %b", head.last, run_last);
          fail_count++;
        end
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
